[rtl/core/fxd_pkg.sv]
// shared types, constants and helpers of the fixed-point decimal digit emitter
package fxd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS      = 10;

  localparam logic [5:0] ASCII_ZERO  = 6'h30;
  localparam logic [5:0] ASCII_POINT = 6'h2E;

  localparam logic [1:0] CFG_COLUMN_STEP = 2'd0;
  localparam logic [1:0] CFG_SMALL_FONT  = 2'd1;

  localparam logic [3:0] COLUMN_STEP_RST = 4'd1;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  start_column;
    logic [2:0]  row;
    logic [3:0]  int_digits;
    logic [3:0]  frac_digits;
  } in_item_t;

  typedef struct packed {
    logic [5:0] char_code;
    logic [7:0] column;
    logic [2:0] row_out;
    logic       font_small;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } div_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_DIV,
    S_OUT
  } state_e;

  function automatic logic [3:0] clamp_digits(input logic [3:0] n);
    clamp_digits = (n > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : n;
  endfunction

endpackage

[rtl/core/fixed_point_decimal_digit_emitter_top.sv]
// top level of the fixed-point decimal digit emitter with its config registers
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   fxd_pkg::in_item_t
// out      output     out_valid_o / out_stall_i fxd_pkg::out_item_t
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// each digit comes from a bit-serial divide by ten, one quotient bit per cycle
// one item is in flight at a time
// out stall holds the current character and pauses the sequencer
// reset sets column step to one and small font to zero
module fixed_point_decimal_digit_emitter_top #(
  parameter int unsigned VALUE_WIDTH = fxd_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fxd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fxd_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_wdata_i
);

  logic [3:0]         step_q, step_d;
  logic               font_q, font_d;
  fxd_pkg::div_ctrl_t div_ctrl;
  fxd_pkg::div_stat_t div_stat;
  logic [VALUE_WIDTH-1:0] value_ext;

  assign cfg_ready_o = 1'b1;
  assign value_ext   = VALUE_WIDTH'(in_data_i.value);

  always_comb begin
    step_d = step_q;
    font_d = font_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fxd_pkg::CFG_COLUMN_STEP: step_d = cfg_wdata_i;
        fxd_pkg::CFG_SMALL_FONT:  font_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= fxd_pkg::COLUMN_STEP_RST;
      font_q <= 1'b0;
    end else begin
      step_q <= step_d;
      font_q <= font_d;
    end
  end

  fxd_div10 #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div10 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .value_i(value_ext),
    .stat_o (div_stat)
  );

  fxd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .step_i     (step_q),
    .font_i     (font_q),
    .div_ctrl_o (div_ctrl),
    .div_stat_i (div_stat)
  );

endmodule

[rtl/core/fxd_div10.sv]
// bit-serial divide by ten over a shift register, one quotient bit per cycle
module fxd_div10 #(
  parameter int unsigned VALUE_WIDTH = fxd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fxd_pkg::div_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output fxd_pkg::div_stat_t     stat_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [3:0]             rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [4:0]             trial;
  logic                   ge;

  assign trial = {rem_q, num_q[VALUE_WIDTH-1]};
  assign ge    = trial >= 5'd10;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.load) begin
      num_d = value_i;
    end else if (ctrl_i.start) begin
      rem_d  = 4'd0;
      cnt_d  = CntW'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 4'(trial - 5'd10) : trial[3:0];
      num_d = {num_q[VALUE_WIDTH-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.digit = rem_q;

`ifndef SYNTHESIS
  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < 4'd10)
    else $error("remainder out of decimal range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("divide started while busy");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("busy with empty bit count");
`endif

endmodule

[rtl/core/fxd_ctrl.sv]
// character sequencer: fraction digits, point, integer digits, column walk
module fxd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fxd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fxd_pkg::out_item_t  out_data_o,
  input  logic [3:0]          step_i,
  input  logic                font_i,
  output fxd_pkg::div_ctrl_t  div_ctrl_o,
  input  fxd_pkg::div_stat_t  div_stat_i
);

  fxd_pkg::state_e state_q, state_d;

  logic [3:0] frac_left_q, frac_left_d;
  logic [3:0] int_left_q, int_left_d;
  logic       point_done_q, point_done_d;
  logic [7:0] col_q, col_d;
  logic [2:0] row_q, row_d;
  logic [5:0] char_q, char_d;
  logic       last_q, last_d;

  logic [3:0] ni, nf;
  logic [4:0] ndig;
  logic [8:0] offset;
  logic [7:0] col_init;
  logic       go_div;

  assign ni       = fxd_pkg::clamp_digits(in_data_i.int_digits);
  assign nf       = fxd_pkg::clamp_digits(in_data_i.frac_digits);
  assign ndig     = {1'b0, ni} + {1'b0, nf};
  assign offset   = {5'd0, step_i} * {4'd0, ndig};
  assign col_init = in_data_i.start_column + offset[7:0];
  assign go_div   = (frac_left_q != 4'd0) || (point_done_q && (int_left_q != 4'd0));

  always_comb begin
    state_d = state_q;
    case (state_q)
      fxd_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fxd_pkg::S_NEXT;
      end
      fxd_pkg::S_NEXT: begin
        if (go_div) state_d = fxd_pkg::S_DIV;
        else if (!point_done_q) state_d = fxd_pkg::S_OUT;
        else state_d = fxd_pkg::S_IDLE;
      end
      fxd_pkg::S_DIV: begin
        if (div_stat_i.done) state_d = fxd_pkg::S_OUT;
      end
      fxd_pkg::S_OUT: begin
        if (!out_stall_i) state_d = last_q ? fxd_pkg::S_IDLE : fxd_pkg::S_NEXT;
      end
      default: state_d = fxd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    frac_left_d  = frac_left_q;
    int_left_d   = int_left_q;
    point_done_d = point_done_q;
    col_d        = col_q;
    row_d        = row_q;
    char_d       = char_q;
    last_d       = last_q;
    div_ctrl_o   = '0;
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    case (state_q)
      fxd_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          div_ctrl_o.load = 1'b1;
          frac_left_d     = nf;
          int_left_d      = ni;
          point_done_d    = 1'b0;
          col_d           = col_init;
          row_d           = in_data_i.row;
        end
      end
      fxd_pkg::S_NEXT: begin
        if (go_div) begin
          div_ctrl_o.start = 1'b1;
        end else if (!point_done_q) begin
          char_d       = fxd_pkg::ASCII_POINT;
          last_d       = int_left_q == 4'd0;
          point_done_d = 1'b1;
        end
      end
      fxd_pkg::S_DIV: begin
        if (div_stat_i.done) begin
          char_d = fxd_pkg::ASCII_ZERO + 6'(div_stat_i.digit);
          if (frac_left_q != 4'd0) begin
            frac_left_d = frac_left_q - 4'd1;
            last_d      = 1'b0;
          end else begin
            int_left_d = int_left_q - 4'd1;
            last_d     = int_left_q == 4'd1;
          end
        end
      end
      fxd_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) col_d = col_q - {4'd0, step_i};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fxd_pkg::S_IDLE;
      frac_left_q  <= 4'd0;
      int_left_q   <= 4'd0;
      point_done_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      frac_left_q  <= frac_left_d;
      int_left_q   <= int_left_d;
      point_done_q <= point_done_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    char_q <= char_d;
  end

  assign out_data_o.char_code  = char_q;
  assign out_data_o.column     = col_q;
  assign out_data_o.row_out    = row_q;
  assign out_data_o.font_small = font_i;
  assign out_data_o.last       = last_q;

`ifndef SYNTHESIS
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_q == fxd_pkg::ASCII_POINT) ||
                    ((char_q >= fxd_pkg::ASCII_ZERO) && (char_q <= 6'h39)))
    else $error("illegal character code");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat_i.done |-> state_q == fxd_pkg::S_DIV)
    else $error("divide finished outside divide state");
  a_frac_before_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fxd_pkg::S_DIV && !point_done_q) |-> frac_left_q != 4'd0)
    else $error("integer digit before point");
`endif

endmodule

[tb/digit_stream_checker.sv]
// checker that predicts the character stream of each number and compares it with the block
`timescale 1ns / 1ps

module digit_stream_checker
  import fxd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [3:0]        cfg_wdata_i,
  output int unsigned       mismatches_o,
  output int unsigned       chars_pending_o
);

  out_item_t   expected_chars[$];
  logic [3:0]  step_reg;
  logic        font_reg;
  int unsigned mismatches;

  assign mismatches_o = mismatches;

  function automatic void predict_digits(input in_item_t it);
    out_item_t   ch;
    logic [31:0] num;
    logic [7:0]  col;
    int unsigned n_int;
    int unsigned n_frac;
    num    = it.value;
    n_int  = (it.int_digits > MAX_DIGITS) ? MAX_DIGITS : it.int_digits;
    n_frac = (it.frac_digits > MAX_DIGITS) ? MAX_DIGITS : it.frac_digits;
    col    = 8'(it.start_column + step_reg * (n_int + n_frac));
    ch.row_out    = it.row;
    ch.font_small = font_reg;
    ch.last       = 1'b0;
    for (int i = 0; i < n_frac; i++) begin
      ch.char_code = ASCII_ZERO + 6'(num % 10);
      ch.column    = col;
      expected_chars.push_back(ch);
      col = col - 8'(step_reg);
      num = num / 10;
    end
    ch.char_code = ASCII_POINT;
    ch.column    = col;
    ch.last      = (n_int == 0);
    expected_chars.push_back(ch);
    col = col - 8'(step_reg);
    for (int i = 0; i < n_int; i++) begin
      ch.char_code = ASCII_ZERO + 6'(num % 10);
      ch.column    = col;
      ch.last      = (i + 1 == n_int);
      expected_chars.push_back(ch);
      col = col - 8'(step_reg);
      num = num / 10;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      step_reg        = COLUMN_STEP_RST;
      font_reg        = 1'b0;
      mismatches      = 0;
      chars_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COLUMN_STEP: begin
            step_reg = cfg_wdata_i;
          end
          CFG_SMALL_FONT: begin
            font_reg = cfg_wdata_i[0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0h", $time, out_data_i);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          check_field("char_code", want.char_code, out_data_i.char_code);
          check_field("column", want.column, out_data_i.column);
          check_field("row_out", want.row_out, out_data_i.row_out);
          check_field("font_small", want.font_small, out_data_i.font_small);
          check_field("last", want.last, out_data_i.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_digits(in_data_i);
      end
      chars_pending_o <= expected_chars.size();
    end
  end

endmodule

[tb/testbench.sv]
// top of the testbench: clock, reset, stimulus, config writes, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import fxd_pkg::*;

  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned PHASE_ITEMS  = 61;
  localparam int unsigned N_PHASES     = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_wdata;
  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_request;
  bit          hold_done;
  int unsigned idle_cycles;

  fixed_point_decimal_digit_emitter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  digit_stream_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .mismatches_o    (mismatches),
    .chars_pending_o (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_number(input logic [31:0] value, input logic [7:0] col,
                                           input logic [2:0] row, input logic [3:0] n_int,
                                           input logic [3:0] n_frac);
    in_item_t it;
    it.value        = value;
    it.start_column = col;
    it.row          = row;
    it.int_digits   = n_int;
    it.frac_digits  = n_frac;
    return it;
  endfunction

  function automatic in_item_t random_number();
    in_item_t it;
    it.value        = ($urandom_range(3) == 0) ? 32'($urandom_range(99999)) : $urandom;
    it.start_column = 8'($urandom_range(255));
    it.row          = 3'($urandom_range(7));
    if ($urandom_range(7) == 0) begin
      it.int_digits  = 4'($urandom_range(15));
      it.frac_digits = 4'($urandom_range(15));
    end else begin
      it.int_digits  = 4'($urandom_range(4));
      it.frac_digits = 4'($urandom_range(3));
    end
    return it;
  endfunction

  task automatic send_number(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [3:0]  steps[N_PHASES];
    int unsigned send_idle[N_PHASES];
    int unsigned stalls[N_PHASES];
    in_item_t    directed[$];
    steps         = '{4'd0, 4'd15, 4'd6, 4'd8, 4'd1, 4'd3};
    send_idle     = '{0, 71, 0, 32, 0, 71};
    stalls        = '{0, 0, 71, 32, 0, 0};
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_COLUMN_STEP;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_number(32'd0, 8'd0, 3'd0, 4'd0, 4'd0));
    directed.push_back(make_number(32'hFFFFFFFF, 8'd255, 3'd7, 4'd10, 4'd10));
    directed.push_back(make_number(32'd1234567890, 8'd0, 3'd3, 4'd10, 4'd0));
    directed.push_back(make_number(32'hFFFFFFFF, 8'd10, 3'd1, 4'd0, 4'd10));
    directed.push_back(make_number(32'd987654321, 8'd100, 3'd5, 4'd15, 4'd15));
    directed.push_back(make_number(32'd42, 8'd250, 3'd2, 4'd11, 4'd3));
    directed.push_back(make_number(32'd7, 8'd254, 3'd6, 4'd3, 4'd12));
    directed.push_back(make_number(32'd999999999, 8'd255, 3'd4, 4'd9, 4'd0));
    directed.push_back(make_number(32'd10, 8'd0, 3'd0, 4'd1, 4'd1));
    directed.push_back(make_number(32'd123, 8'd128, 3'd7, 4'd5, 4'd2));
    directed.push_back(make_number(32'd1, 8'd0, 3'd0, 4'd0, 4'd1));
    directed.push_back(make_number(32'h80000000, 8'd200, 3'd1, 4'd4, 4'd4));
    directed.push_back(make_number(32'd5, 8'd17, 3'd2, 4'd1, 4'd0));
    directed.push_back(make_number(32'h7FFFFFFF, 8'd60, 3'd3, 4'd2, 4'd14));
    foreach (directed[i]) send_number(directed[i]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_COLUMN_STEP, steps[p]);
      write_reg(CFG_SMALL_FONT, 4'(p[0] ^ 1'b1) | ((p == 2) ? 4'b1110 : 4'b0000));
      if (p == 2) begin
        write_reg(CFG_UNMAPPED, 4'hF);
      end
      send_idle_pct = send_idle[p];
      stall_pct     = stalls[p];
      if (p == 4) begin
        hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) send_number(random_number());
      drain();
    end

    if (mismatches == 0 && chars_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
